// ----- rtl/core/fbca_pkg.sv -----
`default_nettype none

package fbca_pkg;

   localparam int CACHE_DEPTH = 32;
   localparam int BLOCK_BITS  = 24;
   localparam int COUNT_BITS  = $clog2(CACHE_DEPTH + 2);
   localparam int KIND_BITS   = 3;
   localparam int REQ_BITS    = 2;

   typedef logic [BLOCK_BITS-1:0] block_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_FREE     = 2'd0,
      REQ_ALLOCATE = 2'd1,
      REQ_REFILL   = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_code_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_FREED        = 3'd0,
      KIND_ALLOCATED    = 3'd1,
      KIND_OUT_OF_SPACE = 3'd2,
      KIND_SPILL        = 3'd3,
      KIND_FETCH_CHAIN  = 3'd4,
      KIND_REFILL       = 3'd5,
      KIND_REJECTED     = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_DOWN,
      CELL_UP
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_SPILL
   } state_type;

   // Stack control; the op goes to every cell.
   typedef struct packed {
      cell_op_type op;
      logic        plant;
      block_type   inject;
   } stack_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/free_block_chain_allocator.sv -----
`default_nettype none

// Free block allocator with a cached stack of free block numbers held in a
// row of 32 shifting cells, the top of the stack in the first cell. Free,
// allocate, refill words and rejected requests each give one result item. A
// free on a full stack gives 34 result items: the count word, then one entry
// a cycle while the result side accepts, as the cell row rotates once past
// its bottom cell, then the freed item. A new request item is taken only
// once the previous one has finished and the result register can be loaded,
// so a stalled result side holds the input side as well.
module free_block_chain_allocator (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [fbca_pkg::REQ_BITS-1:0] req_type,
   input  fbca_pkg::block_type          req_block_number,
   input  fbca_pkg::block_type          req_refill_word,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [fbca_pkg::KIND_BITS-1:0] rsp_kind,
   output fbca_pkg::block_type          rsp_target_block,
   output fbca_pkg::count_type          rsp_word_index,
   output fbca_pkg::block_type          rsp_word_value,
   output fbca_pkg::block_type          rsp_free_total,
   output logic                         rsp_last
);
   import fbca_pkg::*;

   localparam count_type DEPTH_COUNT = COUNT_BITS'(CACHE_DEPTH);
   localparam block_type DEPTH_BLOCK = BLOCK_BITS'(CACHE_DEPTH);

   state_type      state_ff, state_in;
   count_type      count_ff, count_in;
   block_type      total_ff, total_in;
   logic           refilling_ff, refilling_in;
   count_type      refill_pos_ff, refill_pos_in;
   count_type      spill_idx_ff, spill_idx_in;
   block_type      spill_block_ff, spill_block_in;

   logic           rsp_valid_ff, rsp_valid_in;
   kind_type       rsp_kind_ff, rsp_kind_in;
   block_type      rsp_target_ff, rsp_target_in;
   count_type      rsp_index_ff, rsp_index_in;
   block_type      rsp_value_ff, rsp_value_in;
   block_type      rsp_total_ff, rsp_total_in;
   logic           rsp_last_ff, rsp_last_in;

   stack_ctrl_type stack_ctrl;
   block_type      top_data;
   block_type      bottom_data;
   logic           out_load;
   count_type      clamped_count;
   req_code_type   req_code;

   fbca_stack u_stack (
      .clock       (clock),
      .ctrl        (stack_ctrl),
      .top_data    (top_data),
      .bottom_data (bottom_data)
   );

   assign req_code      = req_code_type'(req_type);
   assign clamped_count = (req_refill_word > DEPTH_BLOCK) ? DEPTH_COUNT
                                                          : req_refill_word[COUNT_BITS-1:0];

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      total_in       = total_ff;
      refilling_in   = refilling_ff;
      refill_pos_in  = refill_pos_ff;
      spill_idx_in   = spill_idx_ff;
      spill_block_in = spill_block_ff;
      out_load       = !rsp_valid_ff || rsp_ready;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_target_in  = rsp_target_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_last_in    = rsp_last_ff;
      stack_ctrl     = '{op: CELL_HOLD, plant: 1'b0, inject: '0};
      req_ready      = (state_ff == ST_IDLE) && out_load;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_kind_in   = KIND_REJECTED;
               rsp_target_in = '0;
               rsp_index_in  = '0;
               rsp_value_in  = '0;
               case (req_code)
                  REQ_FREE: begin
                     if (!refilling_ff) begin
                        if (total_ff != '1) begin
                           total_in = total_ff + 1'b1;
                        end
                        rsp_target_in = req_block_number;
                        if (count_ff >= DEPTH_COUNT) begin
                           // Full stack: the count word goes out now, the
                           // entries follow from the bottom cell.
                           rsp_kind_in    = KIND_SPILL;
                           rsp_value_in   = BLOCK_BITS'(count_ff);
                           rsp_last_in    = 1'b0;
                           spill_block_in = req_block_number;
                           spill_idx_in   = COUNT_BITS'(1);
                           state_in       = ST_SPILL;
                        end else if (count_ff == '0) begin
                           rsp_kind_in = KIND_FREED;
                           stack_ctrl  = '{op: CELL_DOWN, plant: 1'b1,
                                           inject: req_block_number};
                           count_in    = COUNT_BITS'(2);
                        end else begin
                           rsp_kind_in = KIND_FREED;
                           stack_ctrl  = '{op: CELL_DOWN, plant: 1'b0,
                                           inject: req_block_number};
                           count_in    = count_ff + 1'b1;
                        end
                     end
                  end
                  REQ_ALLOCATE: begin
                     if (!refilling_ff) begin
                        if (count_ff == '0 || top_data == '0) begin
                           rsp_kind_in = KIND_OUT_OF_SPACE;
                        end else begin
                           stack_ctrl    = '{op: CELL_UP, plant: 1'b0, inject: '0};
                           count_in      = count_ff - 1'b1;
                           rsp_target_in = top_data;
                           if (total_ff != '0) begin
                              total_in = total_ff - 1'b1;
                           end
                           if (count_ff == COUNT_BITS'(1)) begin
                              // The last cached block heads the next chain.
                              rsp_kind_in   = KIND_FETCH_CHAIN;
                              refilling_in  = 1'b1;
                              refill_pos_in = '0;
                           end else begin
                              rsp_kind_in = KIND_ALLOCATED;
                           end
                        end
                     end
                  end
                  REQ_REFILL: begin
                     if (refilling_ff) begin
                        rsp_kind_in  = KIND_REFILL;
                        rsp_index_in = refill_pos_ff;
                        if (refill_pos_ff == '0) begin
                           count_in     = clamped_count;
                           rsp_value_in = BLOCK_BITS'(clamped_count);
                        end else begin
                           rsp_value_in = req_refill_word;
                           // Only entries up to the count are ever read back.
                           if (refill_pos_ff <= count_ff) begin
                              stack_ctrl = '{op: CELL_DOWN, plant: 1'b0,
                                             inject: req_refill_word};
                           end
                        end
                        if (refill_pos_ff >= DEPTH_COUNT) begin
                           refilling_in  = 1'b0;
                           refill_pos_in = '0;
                        end else begin
                           refill_pos_in = refill_pos_ff + 1'b1;
                        end
                     end
                  end
                  default: begin
                     rsp_kind_in = KIND_REJECTED;
                  end
               endcase
               rsp_total_in = total_in;
            end
         end
         ST_SPILL: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               rsp_target_in = spill_block_ff;
               rsp_total_in  = total_ff;
               if (spill_idx_ff <= DEPTH_COUNT) begin
                  // Rotate the row so that every entry passes the bottom cell once.
                  rsp_kind_in  = KIND_SPILL;
                  rsp_index_in = spill_idx_ff;
                  rsp_value_in = bottom_data;
                  rsp_last_in  = 1'b0;
                  stack_ctrl   = '{op: CELL_DOWN, plant: 1'b0, inject: bottom_data};
                  spill_idx_in = spill_idx_ff + 1'b1;
               end else begin
                  rsp_kind_in  = KIND_FREED;
                  rsp_index_in = '0;
                  rsp_value_in = '0;
                  rsp_last_in  = 1'b1;
                  stack_ctrl   = '{op: CELL_DOWN, plant: 1'b0, inject: spill_block_ff};
                  count_in     = COUNT_BITS'(1);
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         total_ff      <= '0;
         refilling_ff  <= 1'b0;
         refill_pos_ff <= '0;
         spill_idx_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         refilling_ff  <= refilling_in;
         refill_pos_ff <= refill_pos_in;
         spill_idx_ff  <= spill_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      spill_block_ff <= spill_block_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_target_ff  <= rsp_target_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_target_block = rsp_target_ff;
   assign rsp_word_index   = rsp_index_ff;
   assign rsp_word_value   = rsp_value_ff;
   assign rsp_free_total   = rsp_total_ff;
   assign rsp_last         = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_COUNT)
      else $error("cached count exceeds the stack depth");

   assert property (@(posedge clock) disable iff (reset)
      refilling_ff && refill_pos_ff == '0 |-> count_ff == '0)
      else $error("refill started with entries still cached");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SPILL |-> !refilling_ff && count_ff == DEPTH_COUNT
                               && spill_idx_ff != '0)
      else $error("spill running outside a full stack");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_SPILL |-> !rsp_last_ff)
      else $error("spill word marked as the last item");

endmodule

`default_nettype wire

// ----- rtl/core/fbca_cell.sv -----
`default_nettype none

module fbca_cell (
   input  wire                  clock,
   input  fbca_pkg::cell_op_type op,
   input  fbca_pkg::block_type   prev_data,
   input  fbca_pkg::block_type   next_data,
   output fbca_pkg::block_type   data_out
);
   import fbca_pkg::*;

   block_type data_ff;
   block_type data_in;

   always_comb begin
      case (op)
         CELL_HOLD: data_in = data_ff;
         CELL_DOWN: data_in = prev_data;
         CELL_UP:   data_in = next_data;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/fbca_stack.sv -----
`default_nettype none

module fbca_stack (
   input  wire                     clock,
   input  fbca_pkg::stack_ctrl_type ctrl,
   output fbca_pkg::block_type      top_data,
   output fbca_pkg::block_type      bottom_data
);
   import fbca_pkg::*;

   block_type cell_data [CACHE_DEPTH];
   block_type prev_data [CACHE_DEPTH];
   block_type next_data [CACHE_DEPTH];

   // Cell 0 is the top of the stack. Shifting down pushes, shifting up pops.
   // Planting puts the end-of-chain zero in cell 1 under the injected block.
   always_comb begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         if (i == 0) begin
            prev_data[i] = ctrl.inject;
         end else if (i == 1 && ctrl.plant) begin
            prev_data[i] = '0;
         end else begin
            prev_data[i] = cell_data[i-1];
         end
         if (i == CACHE_DEPTH - 1) begin
            next_data[i] = '0;
         end else begin
            next_data[i] = cell_data[i+1];
         end
      end
   end

   for (genvar g = 0; g < CACHE_DEPTH; g++) begin : g_cell
      fbca_cell u_cell (
         .clock     (clock),
         .op        (ctrl.op),
         .prev_data (prev_data[g]),
         .next_data (next_data[g]),
         .data_out  (cell_data[g])
      );
   end

   assign top_data    = cell_data[0];
   assign bottom_data = cell_data[CACHE_DEPTH-1];

endmodule

`default_nettype wire
